>>> hdl/vas_pkg.sv
`timescale 1ns / 1ps
// Package for the voice activity segmenter: register indexes, reset values,
// request codes and the control and status bundles of the ring scan unit.
// No dependencies.
package vas_pkg;

	// Default geometry
	localparam int RING_DEPTH_DEF     = 160000;
	localparam int SAMPLES_PER_MS_DEF = 16;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 15;
	localparam int TIME_W   = 32;
	localparam int MS_W     = 16;
	localparam int WIN_W    = 13;
	localparam int OUT_W    = 18;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// Request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_POLL   = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEECH_THRESH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TRIG   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEECH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_IN        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW    = 3'd6;

	// Register reset values (threshold is 0.02 in Q0.15, truncated)
	localparam logic                RST_CAPTURE_ENABLE = 1'b1;
	localparam logic [LEVEL_W-1:0]  RST_SPEECH_THRESH  = 15'd655;
	localparam logic [MS_W-1:0]     RST_SILENCE_TRIG   = 16'd1200;
	localparam logic [MS_W-1:0]     RST_MAX_SPEECH     = 16'd8000;
	localparam logic [MS_W-1:0]     RST_MIN_SPEECH     = 16'd500;
	localparam logic [MS_W-1:0]     RST_LEAD_IN        = 16'd500;
	localparam logic [WIN_W-1:0]    RST_PEAK_WINDOW    = 13'd800;

	// Requests into the ring scan unit
	typedef struct packed {
		logic wr;    // store one sample beat
		logic scan;  // start a peak scan
	} scan_ctl_t;

	// Status back from the ring scan unit
	typedef struct packed {
		logic               done;  // scan finished, peak is final
		logic [LEVEL_W-1:0] peak;
	} scan_sts_t;

endpackage

>>> hdl/vas_ring_scan.sv
`timescale 1ns / 1ps
// Sample ring memory with one write port and one registered read port, and
// the sequencer that walks the newest entries backward to find the peak.
// Depends on vas_pkg.
module vas_ring_scan #(
	parameter int RING_DEPTH = vas_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vas_pkg::scan_ctl_t                ctl,
	input  logic [$clog2(RING_DEPTH)-1:0]     wr_addr,
	input  logic [vas_pkg::SAMPLE_W-1:0]      wr_data,
	input  logic [$clog2(RING_DEPTH)-1:0]     rd_base,
	input  logic [vas_pkg::WIN_W-1:0]         rd_count,
	output vas_pkg::scan_sts_t                sts
);
	import vas_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [SAMPLE_W-1:0] mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic                busy_q;
	logic [WIN_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    addr_q;
	logic [LEVEL_W-1:0]  peak_q;
	logic                rd_en;
	logic [SAMPLE_W-1:0] neg_data;
	logic [LEVEL_W-1:0]  mag;

	assign rd_en = busy_q && (cnt_q != '0);

	// Ring storage: write a sample beat, read one entry per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// Scan control: count down the window, track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (ctl.scan) begin
				busy_q <= 1'b1;
				cnt_q  <= rd_count;
			end else if (sts.done) begin
				busy_q <= 1'b0;
			end else if (rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Saturating magnitude of the returned sample
	always_comb begin
		neg_data = SAMPLE_W'(~rd_data_s1 + 1'b1);
		if (!rd_data_s1[SAMPLE_W-1]) begin
			mag = rd_data_s1[LEVEL_W-1:0];
		end else if (rd_data_s1[LEVEL_W-1:0] == '0) begin
			mag = '1;
		end else begin
			mag = neg_data[LEVEL_W-1:0];
		end
	end

	// Step the address backward with wrap, keep the running maximum
	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			addr_q <= rd_base;
			peak_q <= '0;
		end else begin
			if (rd_en) begin
				addr_q <= (addr_q == '0) ? LAST_IDX : addr_q - 1'b1;
			end
			if (rd_vld_s1 && (mag > peak_q)) begin
				peak_q <= mag;
			end
		end
	end

	assign sts.done = busy_q && (cnt_q == '0) && !rd_vld_s1;
	assign sts.peak = peak_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> !busy_q)
		else $error("scan started while a scan is running");
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr |-> !busy_q)
		else $error("ring written during a scan");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !busy_q)
		else $error("scan stayed busy after done");
	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(busy_q))
		else $error("read data returned without a scan");
`endif

endmodule

>>> hdl/voice_activity_segmenter_unit.sv
`timescale 1ns / 1ps
// Top level of the voice activity segmenter: config registers, speech
// tracking, segment arithmetic and the in/out beat handshakes.
// Depends on vas_pkg and vas_ring_scan.
//
//   channel  signals                         direction  role
//   in       in_valid/in_ready + 3 fields    input      sample or poll beat
//   out      out_valid/out_ready + 6 fields  output     one result per beat
//   cfg      cfg_wr_en/cfg_index/cfg_wr_data input      register write
//
// A sample beat goes from idle straight to done. A poll beat scans
// min(window, fill) entries, then steps through hit, close, length, cap,
// start and done; one read port, so the scan reads one entry a cycle.
// The ring is not cleared after reset; the fill count keeps unwritten
// entries out of every scan. A new beat is taken while the previous result
// waits in the output register; a result stalls only if that register is
// still full when the next one is finished.
module voice_activity_segmenter_unit #(
	parameter int RING_DEPTH     = vas_pkg::RING_DEPTH_DEF,
	parameter int SAMPLES_PER_MS = vas_pkg::SAMPLES_PER_MS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic signed [vas_pkg::SAMPLE_W-1:0] sample,
	input  logic [vas_pkg::TIME_W-1:0]      now_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vas_pkg::LEVEL_W-1:0]     peak_level,
	output logic                            speaking,
	output logic                            segment_ready,
	output logic                            segment_dropped,
	output logic [vas_pkg::OUT_W-1:0]       segment_start,
	output logic [vas_pkg::OUT_W-1:0]       segment_length,
	input  logic                            cfg_wr_en,
	input  logic [vas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vas_pkg::CFG_W-1:0]       cfg_wr_data
);
	import vas_pkg::*;

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int SPM_W  = $clog2(SAMPLES_PER_MS + 1);
	localparam int SUM_W  = MS_W + 1;
	localparam int LEN_W  = SUM_W + SPM_W;
	localparam int CMP_W  = (LEN_W > FILL_W) ? LEN_W : FILL_W;
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(RING_DEPTH);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_HIT   = 3'd2;
	localparam logic [2:0] ST_CLOSE = 3'd3;
	localparam logic [2:0] ST_LEN   = 3'd4;
	localparam logic [2:0] ST_CAP   = 3'd5;
	localparam logic [2:0] ST_START = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]          state_q;

	// Configuration registers
	logic                cap_en_q;
	logic [LEVEL_W-1:0]  thresh_q;
	logic [MS_W-1:0]     trig_q;
	logic [MS_W-1:0]     max_q;
	logic [MS_W-1:0]     min_q;
	logic [MS_W-1:0]     lead_q;
	logic [WIN_W-1:0]    win_q;

	// Ring and speech state
	logic [IDX_W-1:0]    wi_q;
	logic [FILL_W-1:0]   fill_q;
	logic                in_speech_q;
	logic [TIME_W-1:0]   speech_start_q;
	logic [TIME_W-1:0]   last_speech_q;

	// Per-beat working registers
	logic                is_poll_q;
	logic [TIME_W-1:0]   now_q;
	logic [LEVEL_W-1:0]  peak_q;
	logic                seg_q;
	logic                drop_q;
	logic [MS_W-1:0]     dur_q;
	logic [LEN_W-1:0]    prod_q;
	logic [FILL_W-1:0]   len_q;
	logic [IDX_W-1:0]    start_q;

	// Output register
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  peak_level_q;
	logic                speaking_q;
	logic                seg_ready_q;
	logic                seg_dropped_q;
	logic [OUT_W-1:0]    seg_start_q;
	logic [OUT_W-1:0]    seg_length_q;

	scan_ctl_t           scan_ctl;
	scan_sts_t           scan_sts;
	logic                in_fire;
	logic [IDX_W-1:0]    rd_base;
	logic [WIN_W-1:0]    rd_count;
	logic                hit;
	logic [TIME_W-1:0]   since_last;
	logic [TIME_W-1:0]   dur_raw;
	logic                close_seg;
	logic [MS_W-1:0]     dur_clamp;
	logic                out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign scan_ctl.wr   = in_fire && (req_type == REQ_SAMPLE) && cap_en_q;
	assign scan_ctl.scan = in_fire && (req_type == REQ_POLL);
	assign rd_base  = (wi_q == '0) ? LAST_IDX : wi_q - 1'b1;
	assign rd_count = (FILL_W'(win_q) > fill_q) ? WIN_W'(fill_q) : win_q;

	vas_ring_scan #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.wr_addr  (wi_q),
		.wr_data  (sample),
		.rd_base  (rd_base),
		.rd_count (rd_count),
		.sts      (scan_sts)
	);

	// Speech decision and segment close tests
	assign hit        = peak_q > thresh_q;
	assign since_last = now_q - last_speech_q;
	assign dur_raw    = now_q - speech_start_q;
	assign close_seg  = in_speech_q && (since_last > TIME_W'(trig_q));
	assign dur_clamp  = (dur_raw > TIME_W'(max_q)) ? max_q : dur_raw[MS_W-1:0];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= RST_CAPTURE_ENABLE;
			thresh_q <= RST_SPEECH_THRESH;
			trig_q   <= RST_SILENCE_TRIG;
			max_q    <= RST_MAX_SPEECH;
			min_q    <= RST_MIN_SPEECH;
			lead_q   <= RST_LEAD_IN;
			win_q    <= RST_PEAK_WINDOW;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CAPTURE_ENABLE: cap_en_q <= cfg_wr_data[0];
				REG_SPEECH_THRESH:  thresh_q <= cfg_wr_data[LEVEL_W-1:0];
				REG_SILENCE_TRIG:   trig_q   <= cfg_wr_data[MS_W-1:0];
				REG_MAX_SPEECH:     max_q    <= cfg_wr_data[MS_W-1:0];
				REG_MIN_SPEECH:     min_q    <= cfg_wr_data[MS_W-1:0];
				REG_LEAD_IN:        lead_q   <= cfg_wr_data[MS_W-1:0];
				REG_PEAK_WINDOW:    win_q    <= cfg_wr_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, ring pointers, speech state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wi_q           <= '0;
			fill_q         <= '0;
			in_speech_q    <= 1'b0;
			speech_start_q <= '0;
			last_speech_q  <= '0;
			seg_q          <= 1'b0;
			drop_q         <= 1'b0;
			is_poll_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// Raise valid for a finished beat, drop it once the result is taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						is_poll_q <= (req_type == REQ_POLL);
						seg_q     <= 1'b0;
						drop_q    <= 1'b0;
						if (req_type == REQ_POLL) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
							if (cap_en_q) begin
								wi_q <= (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;
								if (fill_q < DEPTH_F) begin
									fill_q <= fill_q + 1'b1;
								end
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_sts.done) begin
						state_q <= ST_HIT;
					end
				end
				ST_HIT: begin
					if (hit) begin
						if (!in_speech_q) begin
							speech_start_q <= now_q;
						end
						in_speech_q   <= 1'b1;
						last_speech_q <= now_q;
					end
					state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					if (close_seg) begin
						in_speech_q <= 1'b0;
						drop_q      <= (dur_clamp < min_q);
						seg_q       <= !(dur_clamp < min_q);
					end
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working data path registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= now_ms;
		end
		if (scan_sts.done) begin
			peak_q <= scan_sts.peak;
		end
		if (state_q == ST_CLOSE) begin
			dur_q <= dur_clamp;
		end
		// length in samples of speech plus lead-in
		prod_q  <= LEN_W'(SUM_W'(dur_q) + SUM_W'(lead_q)) * LEN_W'(SAMPLES_PER_MS);
		// cap at the number of stored samples
		len_q   <= (CMP_W'(prod_q) > CMP_W'(fill_q)) ? fill_q : FILL_W'(prod_q);
		// step back from the write pointer, wrapping once
		start_q <= (FILL_W'(wi_q) >= len_q) ? IDX_W'(FILL_W'(wi_q) - len_q)
			: IDX_W'(FILL_W'(wi_q) + DEPTH_F - len_q);
	end

	// Load the output register from the finished beat
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			peak_level_q  <= is_poll_q ? peak_q : '0;
			speaking_q    <= in_speech_q;
			seg_ready_q   <= seg_q;
			seg_dropped_q <= drop_q;
			seg_start_q   <= seg_q ? OUT_W'(start_q) : '0;
			seg_length_q  <= seg_q ? OUT_W'(len_q) : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign peak_level      = peak_level_q;
	assign speaking        = speaking_q;
	assign segment_ready   = seg_ready_q;
	assign segment_dropped = seg_dropped_q;
	assign segment_start   = seg_start_q;
	assign segment_length  = seg_length_q;

`ifndef SYNTHESIS
	a_ready_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(segment_ready && segment_dropped))
		else $error("segment both ready and dropped");
	a_closed_not_speaking: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (segment_ready || segment_dropped)) |-> !speaking)
		else $error("closed segment still reports speech");
	a_beat_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");
	a_dropped_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && segment_dropped) |-> (segment_length == '0))
		else $error("dropped segment carries a length");
`endif

endmodule

>>> dv/tb_voice_activity_segmenter_unit.sv
`timescale 1ns / 1ps
// Testbench for voice_activity_segmenter_unit: sample and poll beats with random
// gaps and stalls, checked field by field against a scoreboard that tracks speech.
// Depends on vas_pkg and voice_activity_segmenter_unit; runs a 4096-entry ring.
module tb_voice_activity_segmenter_unit;
	import vas_pkg::*;

	localparam int RING_D         = 4096;
	localparam int SPM            = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 150;
	localparam int FILL_SAMPLES   = 64;

	typedef struct packed {
		logic [LEVEL_W-1:0] peak;
		logic               speaking;
		logic               ready;
		logic               dropped;
		logic [OUT_W-1:0]   start;
		logic [OUT_W-1:0]   length;
	} vad_result_t;

	// Shadow of the segmenter: ring, fill, speech timing and register copies.
	class vad_tracker;
		logic [SAMPLE_W-1:0] ring [RING_D];
		int unsigned         wr_idx;
		int unsigned         fill;
		bit                  in_speech;
		logic [TIME_W-1:0]   speech_start;
		logic [TIME_W-1:0]   speech_last;
		bit                  cap_en     = RST_CAPTURE_ENABLE;
		int unsigned         thresh     = RST_SPEECH_THRESH;
		int unsigned         silence_ms = RST_SILENCE_TRIG;
		int unsigned         max_ms     = RST_MAX_SPEECH;
		int unsigned         min_ms     = RST_MIN_SPEECH;
		int unsigned         lead_ms    = RST_LEAD_IN;
		int unsigned         win        = RST_PEAK_WINDOW;
		vad_result_t         awaited [$];
		int                  errors;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
			REG_CAPTURE_ENABLE: cap_en = val[0];
			REG_SPEECH_THRESH:  thresh = val[LEVEL_W-1:0];
			REG_SILENCE_TRIG:   silence_ms = val;
			REG_MAX_SPEECH:     max_ms = val;
			REG_MIN_SPEECH:     min_ms = val;
			REG_LEAD_IN:        lead_ms = val;
			REG_PEAK_WINDOW:    win = val[WIN_W-1:0];
			default: ;
			endcase
		endfunction

		// Advance the shadow state by one accepted beat and queue its result.
		function void accept_item(logic req, logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
			vad_result_t       res;
			int unsigned       n, i, idx, mag, pk, len;
			logic [TIME_W-1:0] quiet_ms, dur;
			res = '0;
			if (req == REQ_SAMPLE) begin
				if (cap_en) begin
					ring[wr_idx] = smp;
					wr_idx = (wr_idx + 1) % RING_D;
					if (fill < RING_D) fill++;
				end
			end else begin
				// scan the newest samples, never past what was stored
				n = (win > fill) ? fill : win;
				pk = 0;
				for (i = 0; i < n; i++) begin
					idx = (wr_idx + RING_D - 1 - i) % RING_D;
					mag = ring[idx][SAMPLE_W-1] ? 32'h10000 - ring[idx] : ring[idx];
					if (mag > 32767) mag = 32767;
					if (mag > pk) pk = mag;
				end
				res.peak = LEVEL_W'(pk);
				if (pk > thresh) begin
					if (!in_speech) begin
						in_speech = 1'b1;
						speech_start = now;
					end
					speech_last = now;
				end
				// close the segment once silence outlasts the trigger (mod 2^32)
				quiet_ms = now - speech_last;
				if (in_speech && quiet_ms > silence_ms) begin
					dur = now - speech_start;
					in_speech = 1'b0;
					if (dur > max_ms) dur = max_ms;
					if (dur < min_ms) begin
						res.dropped = 1'b1;
					end else begin
						len = (dur + lead_ms) * SPM;
						if (len > fill) len = fill;
						res.ready = 1'b1;
						res.length = OUT_W'(len);
						res.start = OUT_W'((wr_idx + RING_D - len) % RING_D);
					end
				end
			end
			res.speaking = in_speech;
			awaited.push_back(res);
		endfunction

		function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
				errors++;
			end
		endfunction

		// Match one result beat against the oldest prediction.
		function void check_result(vad_result_t got);
			vad_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual peak %0d start %0d length %0d",
					$time, got.peak, got.start, got.length);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("peak_level", want.peak, got.peak);
			compare("speaking", want.speaking, got.speaking);
			compare("segment_ready", want.ready, got.ready);
			compare("segment_dropped", want.dropped, got.dropped);
			compare("segment_start", want.start, got.start);
			compare("segment_length", want.length, got.length);
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        req_type;
	logic signed [SAMPLE_W-1:0]  sample;
	logic [TIME_W-1:0]           now_ms;
	logic                        out_valid;
	logic                        out_ready;
	logic [LEVEL_W-1:0]          peak_level;
	logic                        speaking;
	logic                        segment_ready;
	logic                        segment_dropped;
	logic [OUT_W-1:0]            segment_start;
	logic [OUT_W-1:0]            segment_length;
	logic                        cfg_wr_en;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_wr_data;

	vad_tracker        tracker = new();
	logic [TIME_W-1:0] cur_ms;
	int                items_done;
	int                tx_gap;
	bit                tx_valid_hi;
	bit                tx_idle_on;
	bit                rx_idle_on;
	bit                rx_hold_req;
	int                stuck_cycles;

	voice_activity_segmenter_unit #(
		.RING_DEPTH    (RING_D),
		.SAMPLES_PER_MS(SPM)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else if (arst_n) begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("[voice_activity_segmenter_unit] ERROR");
				$finish;
			end
		end
	end

	// Offer one beat after the drawn gap; hold valid until it is taken.
	task automatic send_item(logic req, logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
		if (!tx_valid_hi) repeat (tx_gap) @(posedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		sample <= smp;
		now_ms <= now;
		do @(posedge clk); while (!in_ready);
		if (!(req == REQ_SAMPLE && !tracker.cap_en)) items_done++;
		tracker.accept_item(req, smp, now);
		tx_gap = tx_idle_on ? $urandom_range(0, 12) : 0;
		if (tx_gap > 0) begin
			in_valid <= 1'b0;
			tx_valid_hi = 1'b0;
		end else begin
			tx_valid_hi = 1'b1;
		end
	endtask

	// Drop valid and wait for every predicted result to come back.
	task automatic wait_idle();
		if (tx_valid_hi) begin
			in_valid <= 1'b0;
			tx_valid_hi = 1'b0;
		end
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		tracker.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_config(logic cap, logic [CFG_W-1:0] thr, logic [CFG_W-1:0] sil,
			logic [CFG_W-1:0] mx, logic [CFG_W-1:0] mn, logic [CFG_W-1:0] lead,
			logic [CFG_W-1:0] win);
		write_reg(REG_CAPTURE_ENABLE, CFG_W'(cap));
		write_reg(REG_SPEECH_THRESH, thr);
		write_reg(REG_SILENCE_TRIG, sil);
		write_reg(REG_MAX_SPEECH, mx);
		write_reg(REG_MIN_SPEECH, mn);
		write_reg(REG_LEAD_IN, lead);
		write_reg(REG_PEAK_WINDOW, win);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_config();
		logic [CFG_W-1:0] thr, sil, mx, mn, lead, win;
		case ($urandom_range(0, 5))
		0: thr = 0;
		1: thr = 32767;
		2, 3: thr = CFG_W'($urandom_range(1, 2000));
		default: thr = CFG_W'($urandom_range(2001, 32766));
		endcase
		case ($urandom_range(0, 5))
		0: sil = 0;
		1: sil = 16'hFFFF;
		default: sil = CFG_W'($urandom_range(1, 2000));
		endcase
		case ($urandom_range(0, 5))
		0: mx = 0;
		1: mx = 16'hFFFF;
		default: mx = CFG_W'($urandom_range(100, 10000));
		endcase
		case ($urandom_range(0, 5))
		0: mn = 0;
		1: mn = 16'hFFFF;
		default: mn = CFG_W'($urandom_range(0, 3000));
		endcase
		case ($urandom_range(0, 5))
		0: lead = 0;
		1: lead = 16'hFFFF;
		default: lead = CFG_W'($urandom_range(0, 1000));
		endcase
		case ($urandom_range(0, 9))
		0: win = 0;
		1: win = 1;
		2: win = 4096;
		3: win = 8191;
		4, 5, 6: win = CFG_W'($urandom_range(2, 16));
		default: win = CFG_W'($urandom_range(17, 64));
		endcase
		set_config(1'b1, thr, sil, mx, mn, lead, win);
	endtask

	// One utterance: loud burst, polls, quiet tail, polls past the trigger, noise.
	task automatic run_episode();
		int unsigned         k, mag, thr;
		logic [SAMPLE_W-1:0] val;
		thr = tracker.thresh;
		k = $urandom_range(1, 6);
		repeat (k) begin
			if (thr >= 32767) begin
				val = SAMPLE_W'($urandom);
			end else begin
				mag = $urandom_range(thr + 1, 32768);
				val = SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
			end
			send_item(REQ_SAMPLE, val, $urandom);
		end
		repeat ($urandom_range(1, 3)) begin
			cur_ms += $urandom_range(0, tracker.silence_ms / 2 + 1);
			send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);
		end
		k = (tracker.win < 24 ? tracker.win : 24) + $urandom_range(0, 2);
		repeat (k) begin
			mag = $urandom_range(0, thr);
			val = SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
			send_item(REQ_SAMPLE, val, $urandom);
		end
		repeat ($urandom_range(1, 3)) begin
			cur_ms += $urandom_range(0, tracker.silence_ms + tracker.silence_ms / 4 + 20);
			send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);
		end
		case ($urandom_range(0, 9))
		0: send_item(REQ_SAMPLE, SAMPLE_W'($urandom), $urandom);
		1: begin
			cur_ms = $urandom;
			send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);
		end
		2: wait_idle();
		default: ;
		endcase
	endtask

	task automatic run_phase(int target);
		int first;
		first = items_done;
		while (items_done - first < target) run_episode();
	endtask

	// Result side: random stalls, one long hold on request.
	initial begin
		int unsigned stall;
		vad_result_t got;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = RX_HOLD_CYCLES;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, 12) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.peak = peak_level;
			got.speaking = speaking;
			got.ready = segment_ready;
			got.dropped = segment_dropped;
			got.start = segment_start;
			got.length = segment_length;
			tracker.check_result(got);
		end
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_SAMPLE;
		sample <= '0;
		now_ms <= '0;
		out_ready <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_CAPTURE_ENABLE;
		cfg_wr_data <= '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring, full-scale samples, negative full scale saturating
		send_item(REQ_POLL, 16'h0000, 32'd0);
		send_item(REQ_SAMPLE, 16'h8000, 32'd0);
		send_item(REQ_SAMPLE, 16'h7FFF, 32'd0);
		send_item(REQ_SAMPLE, 16'hFFFF, 32'd0);
		send_item(REQ_SAMPLE, 16'h0001, 32'd0);
		send_item(REQ_SAMPLE, 16'h0000, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd5);
		wait_idle();
		set_config(1'b1, 655, 1200, 8000, 500, 500, 1);
		// silence equal to the trigger holds, one more ms closes
		send_item(REQ_SAMPLE, 16'h0000, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd1205);
		send_item(REQ_POLL, 16'h0000, 32'd1206);
		// clock stepping backwards reads as a long interval, clamped duration
		send_item(REQ_SAMPLE, 16'h7FFF, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd50);
		send_item(REQ_POLL, 16'h0000, 32'd20);
		send_item(REQ_SAMPLE, 16'h0000, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd10);
		wait_idle();
		// short segment below the minimum is dropped
		set_config(1'b1, 0, 0, 8000, 16'hFFFF, 500, 1);
		send_item(REQ_SAMPLE, 16'h0001, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd100);
		send_item(REQ_POLL, 16'h0000, 32'd101);
		send_item(REQ_SAMPLE, 16'h0000, 32'd0);
		send_item(REQ_POLL, 16'h0000, 32'd102);

		// all registers at their low end, capture off
		wait_idle();
		set_config(1'b0, 0, 0, 0, 0, 0, 0);
		cur_ms = $urandom;
		run_phase(40);

		for (int p = 0; p < 7; p++) begin
			wait_idle();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (p == 2) begin
				tx_idle_on = 1'b0;
				rx_hold_req = 1'b1;
			end
			cur_ms = (p == 4) ? 32'hFFFF_F000 : $urandom;
			random_config();
			run_phase(PHASE_ITEMS);
		end

		// all registers at their high end
		wait_idle();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_config(1'b1, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8191);
		cur_ms = $urandom;
		run_phase(40);

		// run of samples under the widest window, then close a segment capped at the fill
		wait_idle();
		tx_idle_on = 1'b0;
		set_config(1'b1, 100, 0, 16'hFFFF, 0, 16'hFFFF, 8191);
		repeat (FILL_SAMPLES) send_item(REQ_SAMPLE, SAMPLE_W'($urandom), $urandom);
		cur_ms += 7;
		send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);
		send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);
		wait_idle();
		set_config(1'b1, 100, 0, 16'hFFFF, 0, 16'hFFFF, 1);
		send_item(REQ_SAMPLE, 16'h0000, $urandom);
		cur_ms += 5;
		send_item(REQ_POLL, SAMPLE_W'($urandom), cur_ms);

		wait_idle();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("[voice_activity_segmenter_unit] OK");
		else
			$display("[voice_activity_segmenter_unit] ERROR");
		$finish;
	end

endmodule
